// ----- rtl/core/ddo_pkg.sv -----
`default_nettype none
package ddo_pkg;

   localparam int ANGLE_W = 16;
   localparam int POS_W = 32;
   localparam int REG_W = 32;
   localparam int TRIG_W = 34;
   localparam int MAG_TRIG_W = 31;
   localparam int TRAV_W = 33;
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = 65;
   localparam int ATAN_W = 30;
   localparam int ATAN_IDX_W = 5;

   localparam logic signed [TRIG_W-1:0] CORDIC_START = 34'sd652032874;
   localparam logic signed [TRIG_W-1:0] PI_Z = 34'sd2147483648;
   localparam logic signed [ANGLE_W-1:0] HALF_PI = 16'sd16384;
   localparam logic [TRIG_W-1:0] UNIT_Q30 = 34'd1073741824;

   localparam int CSR_ADDR_W = 3;
   localparam logic [REG_W-1:0] DPT_RESET = 32'd65536;
   localparam logic [REG_W-1:0] APD_RESET = 32'd45572000;

   typedef enum logic [0:0] {
      CSR_IDX_DPT = 1'b0,
      CSR_IDX_APD = 1'b1
   } ddo_csr_idx_type;

   typedef struct packed {
      logic [REG_W-1:0] distance_per_tick;
      logic [REG_W-1:0] angle_per_distance;
   } ddo_cfg_type;

   typedef struct packed {
      logic                  done;
      logic [MAG_TRIG_W-1:0] cos_mag;
      logic                  cos_neg;
      logic [MAG_TRIG_W-1:0] sin_mag;
      logic                  sin_neg;
   } ddo_trig_type;

   function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         5'd0: v = 30'd536870912;
         5'd1: v = 30'd316933406;
         5'd2: v = 30'd167458907;
         5'd3: v = 30'd85004756;
         5'd4: v = 30'd42667331;
         5'd5: v = 30'd21354465;
         5'd6: v = 30'd10679838;
         5'd7: v = 30'd5340245;
         5'd8: v = 30'd2670163;
         5'd9: v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41721;
         5'd15: v = 30'd20860;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2607;
         5'd19: v = 30'd1303;
         5'd20: v = 30'd651;
         5'd21: v = 30'd325;
         5'd22: v = 30'd162;
         5'd23: v = 30'd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ddo_if.sv -----
`default_nettype none
interface ddo_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] left_count;
   logic [15:0] right_count;
   logic        left_reverse;
   logic        right_reverse;

   modport source (output valid, output left_count, output right_count,
                   output left_reverse, output right_reverse, input ready);
   modport sink (input valid, input left_count, input right_count,
                 input left_reverse, input right_reverse, output ready);
endinterface

interface ddo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pose_x;
   logic signed [31:0] pose_y;
   logic signed [15:0] heading;

   modport source (output valid, output pose_x, output pose_y, output heading,
                   input ready);
   modport sink (input valid, input pose_x, input pose_y, input heading,
                 output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ddo_csr.sv -----
`default_nettype none
module ddo_csr
   import ddo_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [REG_W-1:0]      pwdata,
   output logic [REG_W-1:0]           prdata,
   output logic                       pready,
   output ddo_cfg_type                cfg
);

   logic [REG_W-1:0] dpt_ff, dpt_in;
   logic [REG_W-1:0] apd_ff, apd_in;
   logic             wr_en;
   ddo_csr_idx_type  idx;

   assign idx = ddo_csr_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      dpt_in = dpt_ff;
      apd_in = apd_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_IDX_DPT: dpt_in = pwdata;
            CSR_IDX_APD: apd_in = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_IDX_DPT: prdata = dpt_ff;
         CSR_IDX_APD: prdata = apd_ff;
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dpt_ff <= DPT_RESET;
         apd_ff <= APD_RESET;
      end else begin
         dpt_ff <= dpt_in;
         apd_ff <= apd_in;
      end
   end

   assign cfg.distance_per_tick = dpt_ff;
   assign cfg.angle_per_distance = apd_ff;

endmodule
`default_nettype wire

// ----- rtl/core/ddo_cordic.sv -----
`default_nettype none
module ddo_cordic
   import ddo_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [ANGLE_W-1:0] angle,
   output ddo_trig_type            trig
);

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   typedef enum logic [2:0] {
      CS_IDLE = 3'b001,
      CS_ROT  = 3'b010,
      CS_FIN  = 3'b100
   } cs_state_type;

   cs_state_type               state_ff, state_in;
   logic                       done_ff, done_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic signed [TRIG_W-1:0]   x_ff, x_in;
   logic signed [TRIG_W-1:0]   y_ff, y_in;
   logic signed [TRIG_W-1:0]   z_ff, z_in;
   logic                       flip_ff, flip_in;
   logic [MAG_TRIG_W-1:0]      cos_mag_ff, cos_mag_in;
   logic [MAG_TRIG_W-1:0]      sin_mag_ff, sin_mag_in;
   logic                       cos_neg_ff, cos_neg_in;
   logic                       sin_neg_ff, sin_neg_in;

   logic signed [ANGLE_W-1:0]  ang_s;
   logic signed [TRIG_W-1:0]   z_base;
   logic signed [TRIG_W-1:0]   x_sh, y_sh, atan_v;
   logic [TRIG_W-1:0]          x_abs, y_abs;

   assign ang_s = signed'(angle);
   assign z_base = signed'({{(TRIG_W-ANGLE_W-16){angle[ANGLE_W-1]}}, angle, 16'b0});
   assign x_sh = x_ff >>> step_ff;
   assign y_sh = y_ff >>> step_ff;
   assign atan_v = signed'(TRIG_W'(atan_entry(ATAN_IDX_W'(step_ff))));
   assign x_abs = x_ff[TRIG_W-1] ? unsigned'(-x_ff) : unsigned'(x_ff);
   assign y_abs = y_ff[TRIG_W-1] ? unsigned'(-y_ff) : unsigned'(y_ff);

   always_comb begin
      state_in = state_ff;
      done_in = done_ff;
      step_in = step_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      flip_in = flip_ff;
      cos_mag_in = cos_mag_ff;
      sin_mag_in = sin_mag_ff;
      cos_neg_in = cos_neg_ff;
      sin_neg_in = sin_neg_ff;
      if (start) begin
         state_in = CS_ROT;
         done_in = 1'b0;
         step_in = '0;
         x_in = CORDIC_START;
         y_in = '0;
         if (ang_s > HALF_PI) begin
            z_in = z_base - PI_Z;
            flip_in = 1'b1;
         end else if (ang_s < -HALF_PI) begin
            z_in = z_base + PI_Z;
            flip_in = 1'b1;
         end else begin
            z_in = z_base;
            flip_in = 1'b0;
         end
      end else begin
         unique case (state_ff)
            CS_IDLE: ;
            CS_ROT: begin
               if (!z_ff[TRIG_W-1]) begin
                  x_in = x_ff - y_sh;
                  y_in = y_ff + x_sh;
                  z_in = z_ff - atan_v;
               end else begin
                  x_in = x_ff + y_sh;
                  y_in = y_ff - x_sh;
                  z_in = z_ff + atan_v;
               end
               step_in = step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_in = CS_FIN;
               end
            end
            CS_FIN: begin
               // clamp to unit, keep sign apart for the multiplier
               cos_mag_in = (x_abs > UNIT_Q30) ? UNIT_Q30[MAG_TRIG_W-1:0]
                                               : x_abs[MAG_TRIG_W-1:0];
               sin_mag_in = (y_abs > UNIT_Q30) ? UNIT_Q30[MAG_TRIG_W-1:0]
                                               : y_abs[MAG_TRIG_W-1:0];
               cos_neg_in = x_ff[TRIG_W-1] ^ flip_ff;
               sin_neg_in = y_ff[TRIG_W-1] ^ flip_ff;
               done_in = 1'b1;
               state_in = CS_IDLE;
            end
            default: state_in = CS_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      flip_ff <= flip_in;
      cos_mag_ff <= cos_mag_in;
      sin_mag_ff <= sin_mag_in;
      cos_neg_ff <= cos_neg_in;
      sin_neg_ff <= sin_neg_in;
   end

   assign trig.done = done_ff;
   assign trig.cos_mag = cos_mag_ff;
   assign trig.cos_neg = cos_neg_ff;
   assign trig.sin_mag = sin_mag_ff;
   assign trig.sin_neg = sin_neg_ff;

endmodule
`default_nettype wire

// ----- rtl/core/differential_drive_odometry_unit.sv -----
`default_nettype none
// an item steps through travel, clamp, heading update, a wait for the cordic rotation,
// x projection and add, y projection and add, and done; a new item is taken only in idle
// one shared 33x32 multiplier handles travel, heading and both projections
// a waiting result sits in the output register while the next item is taken
// reset (synchronous, active high) clears position, heading and last counts to zero
// and loads distance_per_tick = 65536 and angle_per_distance = 45572000
module differential_drive_odometry_unit
   import ddo_pkg::*;
#(
   parameter int CORDIC_STEPS = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ddo_req_if.sink                    req_ch,
   ddo_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [REG_W-1:0]      csr_pwdata,
   output logic [REG_W-1:0]           csr_prdata,
   output logic                       csr_pready
);

   localparam int CNT_W = COUNT_BITS;
   localparam int INC_W = COUNT_BITS + 1;
   localparam int SUM_W = COUNT_BITS + 2;
   localparam int MAG_W = COUNT_BITS + 1;
   localparam int ADD_W = POS_W + 3;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_TRAVEL = 13'b0000000000010,
      ST_CLAMP  = 13'b0000000000100,
      ST_HEAD1  = 13'b0000000001000,
      ST_HEAD2  = 13'b0000000010000,
      ST_HEAD3  = 13'b0000000100000,
      ST_HEAD4  = 13'b0000001000000,
      ST_WAIT   = 13'b0000010000000,
      ST_PROJX  = 13'b0000100000000,
      ST_ADDX   = 13'b0001000000000,
      ST_PROJY  = 13'b0010000000000,
      ST_ADDY   = 13'b0100000000000,
      ST_DONE   = 13'b1000000000000
   } st_type;

   ddo_cfg_type  cfg;
   ddo_trig_type trig;

   st_type               state_ff, state_in;
   logic [CNT_W-1:0]     last_l_ff, last_l_in;
   logic [CNT_W-1:0]     last_r_ff, last_r_in;
   logic [POS_W-1:0]     pos_x_ff, pos_x_in;
   logic [POS_W-1:0]     pos_y_ff, pos_y_in;
   logic [ANGLE_W-1:0]   heading_ff, heading_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [MAG_W-1:0]     tmag_ff, tmag_in;
   logic [MAG_W-1:0]     hmag_ff, hmag_in;
   logic                 tneg_ff, tneg_in;
   logic                 hneg_ff, hneg_in;
   logic [TRAV_W-1:0]    trav_ff, trav_in;
   logic [ANGLE_W-1:0]   p1h_ff, p1h_in;
   logic [ANGLE_W-1:0]   hacc_ff, hacc_in;
   logic [MUL_P_W-1:0]   prod_ff;
   logic [POS_W-1:0]     rsp_x_ff, rsp_x_in;
   logic [POS_W-1:0]     rsp_y_ff, rsp_y_in;
   logic [ANGLE_W-1:0]   rsp_h_ff, rsp_h_in;

   logic                 req_fire, rsp_fire, out_free;
   logic [CNT_W-1:0]     lc, rc, dl_raw, dr_raw;
   logic [INC_W-1:0]     dl_s, dr_s, dl, dr;
   logic [SUM_W-1:0]     sum, diff;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   mul_p;
   logic [TRAV_W-1:0]    proj_d;
   logic [POS_W-1:0]     add_pos;
   logic                 add_sub;
   logic [ADD_W-1:0]     add_r;
   logic [POS_W-1:0]     add_sat;
   logic [ANGLE_W-1:0]   head_q, head_qs;

   ddo_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   ddo_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (req_fire),
      .angle (heading_ff),
      .trig  (trig)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire = req_ch.valid & req_ch.ready;
   assign rsp_fire = rsp_valid_ff & rsp_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // wrap-aware wheel increments
   assign lc = CNT_W'(req_ch.left_count);
   assign rc = CNT_W'(req_ch.right_count);
   assign dl_raw = lc - last_l_ff;
   assign dr_raw = rc - last_r_ff;
   assign dl_s = {dl_raw[CNT_W-1], dl_raw};
   assign dr_s = {dr_raw[CNT_W-1], dr_raw};
   assign dl = req_ch.left_reverse ? (~dl_s + 1'b1) : dl_s;
   assign dr = req_ch.right_reverse ? (~dr_s + 1'b1) : dr_s;
   assign sum = {dl[INC_W-1], dl} + {dr[INC_W-1], dr};
   assign diff = {dr[INC_W-1], dr} - {dl[INC_W-1], dl};

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_TRAVEL: begin
            mul_a = MUL_A_W'(tmag_ff);
            mul_b = cfg.distance_per_tick;
         end
         ST_HEAD1: begin
            mul_a = MUL_A_W'(hmag_ff);
            mul_b = cfg.distance_per_tick;
         end
         ST_HEAD2: begin
            mul_a = MUL_A_W'(prod_ff[31:0]);
            mul_b = cfg.angle_per_distance;
         end
         ST_HEAD3: begin
            mul_a = MUL_A_W'(p1h_ff);
            mul_b = cfg.angle_per_distance;
         end
         ST_PROJX: begin
            mul_a = MUL_A_W'(trav_ff);
            mul_b = MUL_B_W'(trig.cos_mag);
         end
         ST_PROJY: begin
            mul_a = MUL_A_W'(trav_ff);
            mul_b = MUL_B_W'(trig.sin_mag);
         end
         default: ;
      endcase
   end

   assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   // shared saturating position adder
   assign proj_d = prod_ff[TRAV_W+29:30];
   assign add_pos = (state_ff == ST_ADDX) ? pos_x_ff : pos_y_ff;
   assign add_sub = tneg_ff ^ ((state_ff == ST_ADDX) ? trig.cos_neg : trig.sin_neg);
   assign add_r = add_sub ? ({{3{add_pos[POS_W-1]}}, add_pos} - ADD_W'(proj_d))
                          : ({{3{add_pos[POS_W-1]}}, add_pos} + ADD_W'(proj_d));

   always_comb begin
      if (!add_r[ADD_W-1] && (add_r[ADD_W-2:POS_W-1] != '0)) begin
         add_sat = {1'b0, {(POS_W-1){1'b1}}};
      end else if (add_r[ADD_W-1] && (add_r[ADD_W-2:POS_W-1] != '1)) begin
         add_sat = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         add_sat = add_r[POS_W-1:0];
      end
   end

   assign head_q = hacc_ff + prod_ff[ANGLE_W-1:0];
   assign head_qs = hneg_ff ? (~head_q + 1'b1) : head_q;

   always_comb begin
      state_in = state_ff;
      last_l_in = last_l_ff;
      last_r_in = last_r_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      heading_in = heading_ff;
      rsp_valid_in = rsp_valid_ff;
      tmag_in = tmag_ff;
      hmag_in = hmag_ff;
      tneg_in = tneg_ff;
      hneg_in = hneg_ff;
      trav_in = trav_ff;
      p1h_in = p1h_ff;
      hacc_in = hacc_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_h_in = rsp_h_ff;
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               last_l_in = lc;
               last_r_in = rc;
               tneg_in = sum[SUM_W-1];
               hneg_in = diff[SUM_W-1];
               tmag_in = sum[SUM_W-1] ? MAG_W'(~sum + 1'b1) : MAG_W'(sum);
               hmag_in = diff[SUM_W-1] ? MAG_W'(~diff + 1'b1) : MAG_W'(diff);
               state_in = ST_TRAVEL;
            end
         end
         ST_TRAVEL: state_in = ST_CLAMP;
         ST_CLAMP: begin
            // half the product, clamped to 2^33 - 1
            trav_in = (prod_ff[MUL_P_W-1:TRAV_W+1] != '0) ? '1 : prod_ff[TRAV_W:1];
            state_in = ST_HEAD1;
         end
         ST_HEAD1: state_in = ST_HEAD2;
         ST_HEAD2: begin
            p1h_in = prod_ff[47:32];
            state_in = ST_HEAD3;
         end
         ST_HEAD3: begin
            hacc_in = prod_ff[47:32];
            state_in = ST_HEAD4;
         end
         ST_HEAD4: begin
            heading_in = heading_ff + head_qs;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (trig.done) begin
               state_in = ST_PROJX;
            end
         end
         ST_PROJX: state_in = ST_ADDX;
         ST_ADDX: begin
            pos_x_in = add_sat;
            state_in = ST_PROJY;
         end
         ST_PROJY: state_in = ST_ADDY;
         ST_ADDY: begin
            pos_y_in = add_sat;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_x_in = pos_x_ff;
               rsp_y_in = pos_y_ff;
               rsp_h_in = heading_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_l_ff <= '0;
         last_r_ff <= '0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         heading_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_l_ff <= last_l_in;
         last_r_ff <= last_r_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         heading_ff <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tmag_ff <= tmag_in;
      hmag_ff <= hmag_in;
      tneg_ff <= tneg_in;
      hneg_ff <= hneg_in;
      trav_ff <= trav_in;
      p1h_ff <= p1h_in;
      hacc_ff <= hacc_in;
      prod_ff <= mul_p;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_h_ff <= rsp_h_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.pose_x = signed'(rsp_x_ff);
   assign rsp_ch.pose_y = signed'(rsp_y_ff);
   assign rsp_ch.heading = signed'(rsp_h_ff);

   // the rotation restarts on every accepted item
   a_cordic_restart: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_TRAVEL) && !trig.done)
      else $error("cordic not restarted on item accept");

   // projection only uses a finished rotation
   a_proj_trig_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROJX || state_ff == ST_PROJY) |-> trig.done)
      else $error("projection before cordic done");

   // a result appears only out of the final sequencer step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done step");

   // heading moves only in its update step
   a_heading_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (heading_ff != $past(heading_ff))) |-> $past(state_ff == ST_HEAD4))
      else $error("heading changed outside update step");

endmodule
`default_nettype wire

// ----- dv/tb_differential_drive_odometry_unit.sv -----
module tb_differential_drive_odometry_unit
   import ddo_pkg::*;
;

   localparam int STEPS = 16;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int PHASES = 8;
   localparam int SETTLE_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT = 10;
   localparam longint HALF_TURN = 64'sd2147483648;
   localparam longint UNIT = 64'sd1073741824;
   localparam longint CORDIC_X0 = 64'sd652032874;
   localparam longint unsigned TRAVEL_CAP = 64'h1_FFFF_FFFF;
   localparam longint ATAN_TAB [0:23] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41721, 20860, 10430, 5215,
      2607, 1303, 651, 325, 162, 81
   };

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic signed [15:0] heading;
   } pose_type;

   class odometry_scoreboard;
      logic [31:0] dpt;
      logic [31:0] apd;
      longint      pos_x;
      longint      pos_y;
      logic [15:0] hdg;
      logic [15:0] last_l;
      logic [15:0] last_r;
      pose_type    expected_poses[$];
      int          mismatches;
      int          checked;

      function new();
         dpt = DPT_RESET;
         apd = APD_RESET;
         pos_x = 0;
         pos_y = 0;
         hdg = '0;
         last_l = '0;
         last_r = '0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void set_reg(ddo_csr_idx_type idx, logic [31:0] value);
         case (idx)
            CSR_IDX_DPT: dpt = value;
            CSR_IDX_APD: apd = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_poses.size();
      endfunction

      function longint tick_delta(logic [15:0] cur, logic [15:0] last, logic rev);
         logic [15:0] d;
         longint      s;
         d = cur - last;
         s = longint'($signed(d));
         return rev ? -s : s;
      endfunction

      function void heading_unit_vector(input logic [15:0] ang, output longint c,
                                        output longint s);
         longint a, z, x, y, nx;
         bit     flip;
         a = longint'($signed(ang));
         z = a * 65536;
         x = CORDIC_X0;
         y = 0;
         flip = 0;
         if (a > 16384) begin
            z -= HALF_TURN;
            flip = 1;
         end else if (a < -16384) begin
            z += HALF_TURN;
            flip = 1;
         end
         for (int i = 0; i < STEPS && i < 24; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z -= ATAN_TAB[i];
            end else begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z += ATAN_TAB[i];
            end
            x = nx;
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         c = (x > UNIT) ? UNIT : (x < -UNIT) ? -UNIT : x;
         s = (y > UNIT) ? UNIT : (y < -UNIT) ? -UNIT : y;
      endfunction

      function longint move_along(longint pos, longint unsigned tmag, bit tneg, longint f);
         bit              fneg;
         longint unsigned fm;
         longint unsigned p;
         longint          d;
         longint          r;
         fneg = (f < 0);
         fm = fneg ? -f : f;
         p = tmag * fm;
         d = p >> 30;
         r = pos + ((tneg != fneg) ? -d : d);
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         return r;
      endfunction

      function void predict_pose(logic [15:0] lc, logic [15:0] rc, logic lrev, logic rrev);
         longint          dl, dr, sum, diff, cs, sn;
         longint unsigned tmag, hmag, m;
         bit              tneg, hneg;
         logic [15:0]     q;
         pose_type        e;
         dl = tick_delta(lc, last_l, lrev);
         dr = tick_delta(rc, last_r, rrev);
         last_l = lc;
         last_r = rc;
         sum = dl + dr;
         diff = dr - dl;
         tneg = (sum < 0);
         hneg = (diff < 0);
         tmag = tneg ? -sum : sum;
         hmag = hneg ? -diff : diff;
         tmag = (tmag * dpt) >> 1;
         if (tmag > TRAVEL_CAP) tmag = TRAVEL_CAP;
         heading_unit_vector(hdg, cs, sn);
         pos_x = move_along(pos_x, tmag, tneg, cs);
         pos_y = move_along(pos_y, tmag, tneg, sn);
         m = hmag * dpt * apd;
         q = m[47:32];
         if (hneg) q = 16'd0 - q;
         hdg = hdg + q;
         e.pose_x = pos_x[31:0];
         e.pose_y = pos_y[31:0];
         e.heading = hdg;
         expected_poses.push_back(e);
      endfunction

      function void check_pose(pose_type got);
         pose_type e;
         checked++;
         if (expected_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: x=%0d y=%0d heading=%0d",
                        got.pose_x, got.pose_y, got.heading);
            return;
         end
         e = expected_poses.pop_front();
         if (got.pose_x !== e.pose_x || got.pose_y !== e.pose_y ||
             got.heading !== e.heading) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch: expected x=%0d y=%0d heading=%0d, got x=%0d y=%0d heading=%0d",
                        e.pose_x, e.pose_y, e.heading, got.pose_x, got.pose_y, got.heading);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [REG_W-1:0]      csr_pwdata;
   logic [REG_W-1:0]      csr_prdata;
   logic                  csr_pready;

   ddo_req_if req_ch ();
   ddo_rsp_if rsp_ch ();

   differential_drive_odometry_unit #(
      .CORDIC_STEPS(STEPS),
      .COUNT_BITS(16)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   odometry_scoreboard sb = new();
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          idle_cycles = 0;
   int          items_sent = 0;
   logic [15:0] gen_left = '0;
   logic [15:0] gen_right = '0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      pose_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.predict_pose(req_ch.left_count, req_ch.right_count,
                            req_ch.left_reverse, req_ch.right_reverse);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.pose_x = rsp_ch.pose_x;
            got.pose_y = rsp_ch.pose_y;
            got.heading = rsp_ch.heading;
            sb.check_pose(got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_item(input logic [15:0] lc, input logic [15:0] rc,
                            input logic lrev, input logic rrev);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.left_count <= lc;
      req_ch.right_count <= rc;
      req_ch.left_reverse <= lrev;
      req_ch.right_reverse <= rrev;
      gen_left = lc;
      gen_right = rc;
      items_sent++;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_delta(input int dl, input int dr, input logic lrev, input logic rrev);
      send_item(gen_left + 16'(dl), gen_right + 16'(dr), lrev, rrev);
   endtask

   task automatic random_item();
      int step_kind;
      int dl;
      int dr;
      step_kind = $urandom_range(99);
      if (step_kind < 70) begin
         dl = int'($urandom_range(400)) - 200;
         if ($urandom_range(1))
            dr = dl + int'($urandom_range(40)) - 20;
         else
            dr = int'($urandom_range(400)) - 200;
      end else if (step_kind < 85) begin
         case ($urandom_range(4))
            0: dl = -32768;
            1: dl = 32767;
            2: dl = 0;
            3: dl = 1;
            default: dl = -1;
         endcase
         dr = ($urandom_range(1)) ? -dl : int'($urandom_range(65535));
      end else begin
         dl = int'($urandom_range(65535));
         dr = int'($urandom_range(65535));
      end
      send_delta(dl, dr, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input ddo_csr_idx_type idx, input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 74;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct = 74;
         end
         default: begin
            send_idle_pct = 20;
            stall_pct = 20;
         end
      endcase
   endtask

   initial begin
      logic [31:0] dpt_val;
      logic [31:0] apd_val;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.left_count = '0;
      req_ch.right_count = '0;
      req_ch.left_reverse = 1'b0;
      req_ch.right_reverse = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset values, straight runs, reverse flags, turns through all quadrants
      send_delta(0, 0, 1'b0, 1'b0);
      send_delta(100, 100, 1'b0, 1'b0);
      send_delta(0, 0, 1'b1, 1'b1);
      send_delta(-40, -40, 1'b1, 1'b1);
      send_delta(-40, -40, 1'b0, 1'b0);
      send_delta(40, 40, 1'b1, 1'b1);
      repeat (5) send_delta(10, 70, 1'b0, 1'b0);
      send_delta(60, -20, 1'b0, 1'b1);
      // most negative increment, both signs of the flag
      send_delta(-32768, 0, 1'b1, 1'b0);
      send_delta(0, -32768, 1'b0, 1'b1);
      send_delta(-32768, -32768, 1'b0, 1'b0);
      send_delta(32767, 32767, 1'b0, 1'b0);
      send_delta(32767, -32768, 1'b0, 1'b0);
      // counter wrap
      send_item(16'hFFFF, 16'hFFFE, 1'b0, 1'b0);
      send_item(16'h0003, 16'h0001, 1'b0, 1'b0);
      drain();

      // huge travel clamp and saturation at both ends
      write_reg(CSR_IDX_DPT, 32'hFFFF_FFFF);
      write_reg(CSR_IDX_APD, 32'hFFFF_FFFF);
      send_delta(-32768, -32768, 1'b1, 1'b1);
      send_delta(32767, 32767, 1'b0, 1'b0);
      send_delta(-32768, -32768, 1'b0, 1'b0);
      send_delta(-32768, -32768, 1'b0, 1'b0);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               dpt_val = DPT_RESET;
               apd_val = APD_RESET;
            end
            1: begin
               dpt_val = 32'd0;
               apd_val = 32'd0;
            end
            2: begin
               dpt_val = 32'hFFFF_FFFF;
               apd_val = 32'hFFFF_FFFF;
            end
            3: begin
               dpt_val = $urandom_range(32'h0004_0000, 32'h0000_0400);
               apd_val = $urandom;
            end
            4: begin
               dpt_val = $urandom;
               apd_val = $urandom_range(32'h1000_0000);
            end
            5: begin
               dpt_val = 32'd32768;
               apd_val = 32'd91144000;
            end
            6: begin
               dpt_val = $urandom;
               apd_val = $urandom;
            end
            default: begin
               dpt_val = $urandom_range(32'h0002_0000);
               apd_val = $urandom;
            end
         endcase
         write_reg(CSR_IDX_DPT, dpt_val);
         write_reg(CSR_IDX_APD, apd_val);
         set_idle(idle_mode_type'(phase % 4));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == ITEMS_PER_PHASE / 2) drain();
            random_item();
         end
         drain();
      end

      $display("run covered %0d items over %0d register settings and four idle patterns",
               items_sent, PHASES + 2);
      $display("%0d results checked, %0d mismatches, %0d still waiting",
               sb.checked, sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
